[src/mcr_pkg.sv]
package mcr_pkg;

   localparam int MAX_RADIUS_DEF = 32;

   localparam int COORD_W = 16;
   localparam int CENTER_W = 15;
   localparam int RAD_W = 6;
   localparam int OFS_W = 8;
   localparam int ERR_W = 10;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [CENTER_W-1:0] center_type;
   typedef logic [RAD_W-1:0] radius_type;
   typedef logic signed [OFS_W-1:0] ofs_type;
   typedef logic signed [ERR_W-1:0] err_type;

   // centre plus or minus an octant offset, kept to 16 bits
   function automatic coord_type place(coord_type c, ofs_type o, logic neg);
      coord_type ext;
      ext = COORD_W'(o);
      return neg ? (c - ext) : (c + ext);
   endfunction

endpackage

[src/midpoint_circle_rasterizer.sv]
// Midpoint circle rasterizer: one circle request in, two items per loop pass out.
// The request is registered into the sequencer, then the first item into the output
// slot once it is free; a zero radius gives no item and the block is ready again in the
// next cycle. A pass walks ST_HALF0 (emit half 0, y step), ST_STEPX (x step), ST_HALF1
// (emit half 1); emits wait while rsp_stall holds, and requests wait for the circle's end.
// Reset: synchronous, active high; clears the sequencer and the output valid.
module midpoint_circle_rasterizer #(
   parameter int MAX_RADIUS = mcr_pkg::MAX_RADIUS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  mcr_pkg::center_type req_center_x,
   input  mcr_pkg::center_type req_center_y,
   input  mcr_pkg::radius_type req_radius,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mcr_pkg::coord_type  rsp_pa_x,
   output mcr_pkg::coord_type  rsp_pa_y,
   output mcr_pkg::coord_type  rsp_pb_x,
   output mcr_pkg::coord_type  rsp_pb_y,
   output mcr_pkg::coord_type  rsp_pc_x,
   output mcr_pkg::coord_type  rsp_pc_y,
   output mcr_pkg::coord_type  rsp_pd_x,
   output mcr_pkg::coord_type  rsp_pd_y,
   output logic                rsp_half,
   output logic                rsp_last
);
   import mcr_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_HALF0, ST_STEPX, ST_HALF1} state_type;

   state_type  state_ff, state_in;
   coord_type  cx_ff, cx_in, cy_ff, cy_in;
   ofs_type    x_ff, x_in, y_ff, y_in;   // live loop offsets
   ofs_type    ox_ff, ox_in, oy_ff, oy_in; // offsets of the pass being emitted
   err_type    err_ff, err_in;
   err_type    bias_ff, bias_in;          // ddx - 2r
   err_type    ddy_ff, ddy_in;

   logic       rsp_valid_ff, rsp_valid_in;
   coord_type  pa_x_ff, pa_x_in, pa_y_ff, pa_y_in;
   coord_type  pb_x_ff, pb_x_in, pb_y_ff, pb_y_in;
   coord_type  pc_x_ff, pc_x_in, pc_y_ff, pc_y_in;
   coord_type  pd_x_ff, pd_x_in, pd_y_ff, pd_y_in;
   logic       half_ff, half_in, last_ff, last_in;

   radius_type r_clamp;
   err_type    err_init;
   err_type    add_op;
   err_type    err_sum;
   err_type    bias_next;
   logic       slot_free;
   logic       done;

   // clamp the radius; the loop error starts at 1 - 2r, which is also ddx - 2r
   assign r_clamp = (req_radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : req_radius;
   assign err_init = err_type'(1) - (err_type'(r_clamp) <<< 1);

   // one shared error adder: ddy on the y step, the stepped bias on the x step
   assign bias_next = bias_ff + err_type'(2);
   assign add_op = (state_ff == ST_HALF0) ? ddy_ff : bias_next;
   assign err_sum = err_ff + add_op;

   // output slot takes a new item when empty or being drained this cycle
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign done = (x_ff < y_ff);

   always_comb begin
      state_in = state_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      x_in = x_ff;
      y_in = y_ff;
      ox_in = ox_ff;
      oy_in = oy_ff;
      err_in = err_ff;
      bias_in = bias_ff;
      ddy_in = ddy_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      pa_x_in = pa_x_ff;
      pa_y_in = pa_y_ff;
      pb_x_in = pb_x_ff;
      pb_y_in = pb_y_ff;
      pc_x_in = pc_x_ff;
      pc_y_in = pc_y_ff;
      pd_x_in = pd_x_ff;
      pd_y_in = pd_y_ff;
      half_in = half_ff;
      last_in = last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cx_in = COORD_W'(req_center_x);
               cy_in = COORD_W'(req_center_y);
               x_in = ofs_type'({1'b0, r_clamp}) - ofs_type'(1);
               y_in = '0;
               ddy_in = err_type'(1);
               err_in = err_init;
               bias_in = err_init;
               // zero radius: drop the item, nothing to draw
               state_in = (r_clamp == '0) ? ST_IDLE : ST_HALF0;
            end
         end
         ST_HALF0: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               pa_x_in = place(cx_ff, x_ff, 1'b0);
               pa_y_in = place(cy_ff, y_ff, 1'b0);
               pb_x_in = place(cx_ff, y_ff, 1'b0);
               pb_y_in = place(cy_ff, x_ff, 1'b0);
               pc_x_in = place(cx_ff, y_ff, 1'b1);
               pc_y_in = place(cy_ff, x_ff, 1'b0);
               pd_x_in = place(cx_ff, x_ff, 1'b1);
               pd_y_in = place(cy_ff, y_ff, 1'b0);
               half_in = 1'b0;
               last_in = 1'b0;
               ox_in = x_ff;
               oy_in = y_ff;
               // y step alongside the emit
               if (err_ff <= 0) begin
                  y_in = y_ff + ofs_type'(1);
                  err_in = err_sum;
                  ddy_in = ddy_ff + err_type'(2);
               end
               state_in = ST_STEPX;
            end
         end
         ST_STEPX: begin
            if (err_ff > 0) begin
               x_in = x_ff - ofs_type'(1);
               bias_in = bias_next;
               err_in = err_sum;
            end
            state_in = ST_HALF1;
         end
         ST_HALF1: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               pa_x_in = place(cx_ff, ox_ff, 1'b1);
               pa_y_in = place(cy_ff, oy_ff, 1'b1);
               pb_x_in = place(cx_ff, oy_ff, 1'b1);
               pb_y_in = place(cy_ff, ox_ff, 1'b1);
               pc_x_in = place(cx_ff, oy_ff, 1'b0);
               pc_y_in = place(cy_ff, ox_ff, 1'b1);
               pd_x_in = place(cx_ff, ox_ff, 1'b0);
               pd_y_in = place(cy_ff, oy_ff, 1'b1);
               half_in = 1'b1;
               // the stepped offsets decide whether another pass follows
               last_in = done;
               state_in = done ? ST_IDLE : ST_HALF0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      x_ff <= x_in;
      y_ff <= y_in;
      ox_ff <= ox_in;
      oy_ff <= oy_in;
      err_ff <= err_in;
      bias_ff <= bias_in;
      ddy_ff <= ddy_in;
      pa_x_ff <= pa_x_in;
      pa_y_ff <= pa_y_in;
      pb_x_ff <= pb_x_in;
      pb_y_ff <= pb_y_in;
      pc_x_ff <= pc_x_in;
      pc_y_ff <= pc_y_in;
      pd_x_ff <= pd_x_in;
      pd_y_ff <= pd_y_in;
      half_ff <= half_in;
      last_ff <= last_in;
   end

   // hold the request side while a circle is being walked
   assign req_stall = (state_ff != ST_IDLE);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pa_x = pa_x_ff;
   assign rsp_pa_y = pa_y_ff;
   assign rsp_pb_x = pb_x_ff;
   assign rsp_pb_y = pb_y_ff;
   assign rsp_pc_x = pc_x_ff;
   assign rsp_pc_y = pc_y_ff;
   assign rsp_pd_x = pd_x_ff;
   assign rsp_pd_y = pd_y_ff;
   assign rsp_half = half_ff;
   assign rsp_last = last_ff;

`ifndef NO_ASSERTIONS
   a_pass_in_octant: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HALF0) |-> (x_ff >= y_ff))
      else $error("pass started with x below y");

   a_last_on_half1: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_half) |-> !rsp_last)
      else $error("last flag on a first-half item");

   a_hold_while_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid
         && $stable({rsp_pa_x, rsp_pa_y, rsp_pb_x, rsp_pb_y})
         && $stable({rsp_pc_x, rsp_pc_y, rsp_pd_x, rsp_pd_y})
         && $stable({rsp_half, rsp_last})))
      else $error("stalled item changed or vanished");

   a_half1_follows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEPX) |-> (rsp_valid && !rsp_half))
      else $error("x step without a pending first-half item");
`endif

endmodule

[sim/midpoint_circle_rasterizer_tb.sv]
module midpoint_circle_rasterizer_tb;

   import mcr_pkg::*;

   // Clamp limit of the block under test (default parameter) and the cap on
   // results per circle that the loop never reaches below radius 45.
   localparam int RADIUS_CLAMP = MAX_RADIUS_DEF;
   localparam int RESULT_CAP   = 64;

   // Drain guard and settling time after the last expected result.
   localparam int DRAIN_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 8;

   // Receiver hold-off used to fill the block and back up its input.
   localparam int LONG_HOLD_CYCLES = 200;

   // One result item: four mirrored points plus the half and last flags.
   typedef struct {
      coord_type pa_x;
      coord_type pa_y;
      coord_type pb_x;
      coord_type pb_y;
      coord_type pc_x;
      coord_type pc_y;
      coord_type pd_x;
      coord_type pd_y;
      logic      half;
      logic      last;
   } point_set_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_stall;
   center_type req_center_x = '0;
   center_type req_center_y = '0;
   radius_type req_radius = '0;

   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   coord_type  rsp_pa_x;
   coord_type  rsp_pa_y;
   coord_type  rsp_pb_x;
   coord_type  rsp_pb_y;
   coord_type  rsp_pc_x;
   coord_type  rsp_pc_y;
   coord_type  rsp_pd_x;
   coord_type  rsp_pd_y;
   logic       rsp_half;
   logic       rsp_last;

   // Point sets still owed by the block, oldest first.
   point_set_type pending_points[$];
   int         mismatches = 0;

   // Idling switches: tx_idle belongs to the sending process, rx_idle and
   // hold_len are written with nonblocking assignments so the receiver and
   // the hold-off process always see a settled value at the clock edge.
   bit         tx_idle = 1'b1;
   bit         rx_idle = 1'b1;
   int         hold_len = 0;
   logic       hold_active = 1'b0;
   int         rx_wait = 0;

   midpoint_circle_rasterizer u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_radius   (req_radius),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_pa_x     (rsp_pa_x),
      .rsp_pa_y     (rsp_pa_y),
      .rsp_pb_x     (rsp_pb_x),
      .rsp_pb_y     (rsp_pb_y),
      .rsp_pc_x     (rsp_pc_x),
      .rsp_pc_y     (rsp_pc_y),
      .rsp_pd_x     (rsp_pd_x),
      .rsp_pd_y     (rsp_pd_y),
      .rsp_half     (rsp_half),
      .rsp_last     (rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Walk the midpoint loop for one circle and queue every point set it
   // gives. The offsets start at radius-1 and 0, the error at 1 - 2*radius;
   // y steps first when the error is not positive, then x when it is.
   function automatic void trace_circle(int ctr_x, int ctr_y, int rad);
      point_set_type sets[RESULT_CAP];
      int         ox;
      int         oy;
      int         step_x;
      int         step_y;
      int         err;
      int         n;
      if (rad > RADIUS_CLAMP) begin
         rad = RADIUS_CLAMP;
      end
      ox = rad - 1;
      oy = 0;
      step_x = 1;
      step_y = 1;
      err = step_x - 2 * rad;
      n = 0;
      while (ox >= oy && n + 2 <= RESULT_CAP) begin
         sets[n].pa_x = coord_type'(ctr_x + ox);
         sets[n].pa_y = coord_type'(ctr_y + oy);
         sets[n].pb_x = coord_type'(ctr_x + oy);
         sets[n].pb_y = coord_type'(ctr_y + ox);
         sets[n].pc_x = coord_type'(ctr_x - oy);
         sets[n].pc_y = coord_type'(ctr_y + ox);
         sets[n].pd_x = coord_type'(ctr_x - ox);
         sets[n].pd_y = coord_type'(ctr_y + oy);
         sets[n].half = 1'b0;
         sets[n].last = 1'b0;
         n++;
         sets[n].pa_x = coord_type'(ctr_x - ox);
         sets[n].pa_y = coord_type'(ctr_y - oy);
         sets[n].pb_x = coord_type'(ctr_x - oy);
         sets[n].pb_y = coord_type'(ctr_y - ox);
         sets[n].pc_x = coord_type'(ctr_x + oy);
         sets[n].pc_y = coord_type'(ctr_y - ox);
         sets[n].pd_x = coord_type'(ctr_x + ox);
         sets[n].pd_y = coord_type'(ctr_y - oy);
         sets[n].half = 1'b1;
         sets[n].last = 1'b0;
         n++;
         if (err <= 0) begin
            oy++;
            err += step_y;
            step_y += 2;
         end
         if (err > 0) begin
            ox--;
            step_x += 2;
            err += step_x - 2 * rad;
         end
      end
      // Flag the final set; a zero radius queues nothing at all.
      if (n > 0) begin
         sets[n-1].last = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
         pending_points.insert(pending_points.size(), sets[i]);
      end
   endfunction

   // Count a failure; print only the first ten.
   task automatic note_failure(string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s", msg);
      end
   endtask

   task automatic check_field(string name, coord_type want, coord_type got);
      if (got !== want) begin
         note_failure($sformatf("%s: expected %0d, got %0d", name, want, got));
      end
   endtask

   // Offer one circle request. Drop valid for the drawn gap, then hold the
   // item until an edge sees valid high with stall low. With no gap, valid
   // stays high and only the payload moves on to the next item.
   task automatic send_circle(int cx, int cy, int rad);
      int gap;
      gap = tx_idle ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_center_x <= center_type'(cx);
      req_center_y <= center_type'(cy);
      req_radius   <= radius_type'(rad);
      do @(posedge clock); while (req_stall !== 1'b0);
      trace_circle(cx, cy, rad);
   endtask

   // Lower valid and wait until every owed result has come, then let the
   // block settle, since a zero radius may still be in flight.
   task automatic wait_drained();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (pending_points.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly spread over the whole range, with the two extremes now and then.
   function automatic int pick_center();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         return -16384;
      end else if (sel == 1) begin
         return 16383;
      end
      return int'($urandom_range(0, 32767)) - 16384;
   endfunction

   // Mostly legal radii, some tiny ones and some that must be clamped.
   function automatic int pick_radius();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         return $urandom_range(0, 2);
      end else if (sel == 1) begin
         return $urandom_range(RADIUS_CLAMP + 1, 63);
      end
      return $urandom_range(0, RADIUS_CLAMP);
   endfunction

   // Edge cases: zero radius (alone and back to back), the smallest circles,
   // the largest legal radius, clamped radii, and centres at the extremes.
   task automatic test_directed_cases();
      tx_idle = 1'b1;
      rx_idle <= 1'b1;
      send_circle(0, 0, 0);
      send_circle(0, 0, 1);
      send_circle(0, 0, 2);
      send_circle(100, -50, 5);
      send_circle(0, 0, RADIUS_CLAMP);
      send_circle(0, 0, RADIUS_CLAMP + 1);
      send_circle(0, 0, 63);
      send_circle(-16384, -16384, RADIUS_CLAMP);
      send_circle(16383, 16383, RADIUS_CLAMP);
      send_circle(-16384, 16383, 63);
      send_circle(16383, -16384, 7);
      send_circle(-1, -1, 31);
      send_circle(12345, -12345, 16);
      // Back-to-back zero radii, then a real circle right behind them.
      tx_idle = 1'b0;
      send_circle(5, 5, 0);
      send_circle(5, 5, 0);
      send_circle(5, 5, 3);
      wait_drained();
   endtask

   // Hold the receiver off for a long stretch while the sender keeps
   // offering large circles with no gaps: the block fills and stalls its
   // input. Then pause the sender until every owed result has come.
   task automatic test_back_pressure();
      tx_idle = 1'b0;
      rx_idle <= 1'b1;
      hold_len <= LONG_HOLD_CYCLES;
      for (int i = 0; i < 12; i++) begin
         send_circle(pick_center(), pick_center(), $urandom_range(20, RADIUS_CLAMP));
      end
      wait_drained();
   endtask

   // Full rate on both sides: no idling at all.
   task automatic test_streaming();
      tx_idle = 1'b0;
      rx_idle <= 1'b0;
      for (int i = 0; i < 40; i++) begin
         send_circle(pick_center(), pick_center(), pick_radius());
      end
      wait_drained();
   endtask

   // Random circles in stretches; each stretch redraws which sides idle.
   task automatic test_random_circles();
      for (int i = 0; i < 190; i++) begin
         if (i % 25 == 0) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle <= ($urandom_range(0, 3) != 0);
         end
         send_circle(pick_center(), pick_center(), pick_radius());
      end
      wait_drained();
   endtask

   // Receiver: after each accepted item, stall for a drawn number of
   // cycles; the long hold-off overrides everything while it lasts.
   always @(posedge clock) begin
      if (rsp_valid === 1'b1 && !rsp_stall) begin
         rx_wait = rx_idle ? $urandom_range(0, 6) : 0;
      end else if (rx_wait > 0) begin
         rx_wait--;
      end
      rsp_stall <= hold_active || (rx_wait != 0);
   end

   // Long hold-off, counted here in cycles once a length is requested.
   initial begin
      int hold_left;
      forever begin
         @(posedge clock);
         if (hold_len != 0) begin
            hold_left = hold_len;
            hold_len <= 0;
            hold_active <= 1'b1;
            while (hold_left > 0) begin
               @(posedge clock);
               hold_left--;
            end
            hold_active <= 1'b0;
         end
      end
   end

   // Checker: compare each accepted result with the oldest owed point set.
   always @(posedge clock) begin : check_results
      point_set_type want;
      if (!reset) begin
         if ($isunknown(rsp_valid)) begin
            note_failure("rsp_valid is unknown");
         end else if (rsp_valid && !rsp_stall) begin
            if (pending_points.size() == 0) begin
               note_failure("result arrived with none expected");
            end else begin
               want = pending_points.pop_front();
               check_field("pa_x", want.pa_x, rsp_pa_x);
               check_field("pa_y", want.pa_y, rsp_pa_y);
               check_field("pb_x", want.pb_x, rsp_pb_x);
               check_field("pb_y", want.pb_y, rsp_pb_y);
               check_field("pc_x", want.pc_x, rsp_pc_x);
               check_field("pc_y", want.pc_y, rsp_pc_y);
               check_field("pd_x", want.pd_x, rsp_pd_x);
               check_field("pd_y", want.pd_y, rsp_pd_y);
               check_field("half", coord_type'(want.half), coord_type'(rsp_half));
               check_field("last", coord_type'(want.last), coord_type'(rsp_last));
            end
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      test_directed_cases();
      test_back_pressure();
      test_streaming();
      test_random_circles();
      wait_drained();
      // Anything still owed now never arrived.
      if (pending_points.size() != 0) begin
         note_failure($sformatf("%0d results never arrived", pending_points.size()));
      end
      if (mismatches == 0) begin
         $display("midpoint_circle_rasterizer: match");
      end else begin
         $display("midpoint_circle_rasterizer: mismatch");
      end
      $finish;
   end

   // Guard against a hung block: far beyond the slowest correct run.
   initial begin
      #4000000;
      $display("midpoint_circle_rasterizer: mismatch");
      $finish;
   end

endmodule
